// ===== rtl/core/length_prefixed_event_deframer_top_macros.svh =====
// ---------------------------------------------------------------------------
// length_prefixed_event_deframer_top_macros
// assertion macros used by the deframer parser, empty when SYNTH is set
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_EVENT_DEFRAMER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_EVENT_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define LPED_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LPED_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define LPED_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)

`define LPED_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/core/lped_pkg.sv =====
// ---------------------------------------------------------------------------
// lped_pkg
// shared constants and types of the length-prefixed event deframer
// ---------------------------------------------------------------------------
package lped_pkg;

   localparam int DEF_LENGTH_BYTES = 4;
   localparam int DEF_EVENT_BYTES  = 4;
   localparam int BYTE_BITS        = 8;
   localparam int WORD_BITS        = 32;

   // one result as produced by the parser
   typedef struct packed {
      logic                 valid;
      logic [WORD_BITS-1:0] event_number;
      logic [BYTE_BITS-1:0] payload_byte;
      logic                 payload_valid;
      logic                 frame_last;
      logic                 frame_empty;
      logic                 bad_length;
   } rsp_type;

endpackage

// ===== rtl/core/lped_parser.sv =====
// ---------------------------------------------------------------------------
// lped_parser
// header collection and payload tagging, one byte per accepted request
// ---------------------------------------------------------------------------
`include "length_prefixed_event_deframer_top_macros.svh"

module lped_parser #(
   parameter int LENGTH_BYTES = lped_pkg::DEF_LENGTH_BYTES,
   parameter int EVENT_BYTES  = lped_pkg::DEF_EVENT_BYTES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  take,
   input  logic [lped_pkg::BYTE_BITS-1:0]        in_byte,
   output lped_pkg::rsp_type                     result
);

   localparam int HDR_BYTES = LENGTH_BYTES + EVENT_BYTES;
   localparam int HCW       = $clog2(HDR_BYTES + 1);
   localparam int WB        = lped_pkg::WORD_BITS;
   localparam int BB        = lped_pkg::BYTE_BITS;
   localparam logic [HCW-1:0] HDR_CNT = HCW'(HDR_BYTES);
   localparam logic [HCW-1:0] LEN_CNT = HCW'(LENGTH_BYTES);
   localparam logic [WB-1:0]  HDR_LEN = WB'(HDR_BYTES);

   logic           in_payload_ff,   in_payload_in;
   logic [HCW-1:0] header_count_ff, header_count_in;
   logic [WB-1:0]  declared_len_ff, declared_len_in;
   logic [WB-1:0]  current_event_ff, current_event_in;
   logic [WB-1:0]  bytes_left_ff,   bytes_left_in;

   logic [WB-1:0]  len_base, ev_base, len_new, ev_new, left_dec;
   logic [HCW-1:0] count_inc;

   always_comb begin
      in_payload_in    = in_payload_ff;
      header_count_in  = header_count_ff;
      declared_len_in  = declared_len_ff;
      current_event_in = current_event_ff;
      bytes_left_in    = bytes_left_ff;
      result           = '0;
      result.event_number = current_event_ff;

      left_dec  = bytes_left_ff - WB'(1);
      count_inc = header_count_ff + HCW'(1);
      len_base  = (header_count_ff == '0) ? '0 : declared_len_ff;
      ev_base   = (header_count_ff == '0) ? '0 : current_event_ff;
      len_new   = len_base;
      ev_new    = ev_base;
      if (header_count_ff < LEN_CNT) begin
         // saturate once a nonzero byte would fall off the top
         if (len_base[WB-1 -: BB] != '0) begin
            len_new = '1;
         end else begin
            len_new = {len_base[WB-BB-1:0], in_byte};
         end
      end else begin
         ev_new = {ev_base[WB-BB-1:0], in_byte};
      end

      if (take) begin
         if (in_payload_ff) begin
            bytes_left_in        = left_dec;
            result.valid         = 1'b1;
            result.payload_byte  = in_byte;
            result.payload_valid = 1'b1;
            result.frame_last    = (left_dec == '0);
            if (left_dec == '0) begin
               in_payload_in   = 1'b0;
               header_count_in = '0;
            end
         end else begin
            declared_len_in     = len_new;
            current_event_in    = ev_new;
            result.event_number = ev_new;
            if (count_inc < HDR_CNT) begin
               header_count_in = count_inc;
            end else begin
               header_count_in = '0;
               if (len_new < HDR_LEN) begin
                  result.valid      = 1'b1;
                  result.frame_last = 1'b1;
                  result.bad_length = 1'b1;
               end else if (len_new == HDR_LEN) begin
                  result.valid       = 1'b1;
                  result.frame_last  = 1'b1;
                  result.frame_empty = 1'b1;
               end else begin
                  bytes_left_in = len_new - HDR_LEN;
                  in_payload_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff    <= 1'b0;
         header_count_ff  <= '0;
         declared_len_ff  <= '0;
         current_event_ff <= '0;
         bytes_left_ff    <= '0;
      end else begin
         in_payload_ff    <= in_payload_in;
         header_count_ff  <= header_count_in;
         declared_len_ff  <= declared_len_in;
         current_event_ff <= current_event_in;
         bytes_left_ff    <= bytes_left_in;
      end
   end

   `LPED_ASSERT_IMP(a_payload_gives_result, clock, reset, take && in_payload_ff, result.valid && result.payload_valid, "payload byte without result")
   `LPED_ASSERT_IMP(a_bad_is_last, clock, reset, result.valid && result.bad_length, result.frame_last && !result.payload_valid, "bad length result malformed")
   `LPED_ASSERT_NXT(a_last_ends_frame, clock, reset, take && in_payload_ff && (bytes_left_ff == WB'(1)), !in_payload_ff && (header_count_ff == '0), "frame did not close")
   `LPED_ASSERT_IMP(a_count_in_range, clock, reset, !in_payload_ff, header_count_ff < HDR_CNT, "header count out of range")

endmodule

// ===== rtl/core/lped_out_reg.sv =====
// ---------------------------------------------------------------------------
// lped_out_reg
// result register with valid/ready handshake toward the consumer
// ---------------------------------------------------------------------------
module lped_out_reg (
   input  logic                              clock,
   input  logic                              reset,
   input  lped_pkg::rsp_type                 result,
   output logic                              load_ok,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lped_pkg::WORD_BITS-1:0]    rsp_event_number,
   output logic [lped_pkg::BYTE_BITS-1:0]    rsp_payload_byte,
   output logic                              rsp_payload_valid,
   output logic                              rsp_frame_last,
   output logic                              rsp_frame_empty,
   output logic                              rsp_bad_length
);

   logic              valid_ff, valid_in;
   lped_pkg::rsp_type data_ff,  data_in;

   // the register may be refilled in the cycle it is emptied
   assign load_ok = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load_ok) begin
         valid_in = result.valid;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_event_number  = data_ff.event_number;
   assign rsp_payload_byte  = data_ff.payload_byte;
   assign rsp_payload_valid = data_ff.payload_valid;
   assign rsp_frame_last    = data_ff.frame_last;
   assign rsp_frame_empty   = data_ff.frame_empty;
   assign rsp_bad_length    = data_ff.bad_length;

endmodule

// ===== rtl/core/length_prefixed_event_deframer_top.sv =====
// ---------------------------------------------------------------------------
// length_prefixed_event_deframer_top
// splits a byte stream into length-prefixed frames and tags payload bytes
// ---------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_ready  req_in_byte
//  rsp_      out        rsp_valid / rsp_ready  event number, byte, flags
//
//  one byte per cycle sustained while rsp_ready is high; a request is
//  accepted in the cycle after the previous one, any result is registered
//  and appears in the cycle after acceptance; header bytes add no stall
//  reset is synchronous and returns the parser to header hunting
//  req_ready drops only while a held result waits on rsp_ready
// ---------------------------------------------------------------------------
module length_prefixed_event_deframer_top #(
   parameter int LENGTH_BYTES = lped_pkg::DEF_LENGTH_BYTES,
   parameter int EVENT_BYTES  = lped_pkg::DEF_EVENT_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   // request side
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lped_pkg::BYTE_BITS-1:0]    req_in_byte,
   // result side
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lped_pkg::WORD_BITS-1:0]    rsp_event_number,
   output logic [lped_pkg::BYTE_BITS-1:0]    rsp_payload_byte,
   output logic                              rsp_payload_valid,
   output logic                              rsp_frame_last,
   output logic                              rsp_frame_empty,
   output logic                              rsp_bad_length
);

   lped_pkg::rsp_type result;
   logic              load_ok;
   logic              take;

   // a request is taken whenever the result register can absorb its outcome
   assign req_ready = load_ok;
   assign take      = req_valid && load_ok;

   // header and payload tracking
   lped_parser #(
      .LENGTH_BYTES (LENGTH_BYTES),
      .EVENT_BYTES  (EVENT_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .in_byte (req_in_byte),
      .result  (result)
   );

   // registered result stage
   lped_out_reg u_out (
      .clock             (clock),
      .reset             (reset),
      .result            (result),
      .load_ok           (load_ok),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_number  (rsp_event_number),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_frame_last    (rsp_frame_last),
      .rsp_frame_empty   (rsp_frame_empty),
      .rsp_bad_length    (rsp_bad_length)
   );

endmodule
